[rtl/core/lut3d_trilinear_sampler_top_assert.svh]
// assertion macros for the 3d lut sampler
`ifndef LUT3D_TRILINEAR_SAMPLER_TOP_ASSERT_SVH
`define LUT3D_TRILINEAR_SAMPLER_TOP_ASSERT_SVH

// same-cycle implication
`define LTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lts_pkg.sv]
// ----------------------------------------------------------------------------
// lts_pkg
// shared constants, types and arithmetic helpers of the 3d lut sampler
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int unsigned GRID_MAX    = 32;
  localparam int unsigned CW          = $clog2(GRID_MAX);
  localparam int unsigned ZY_W        = 2 * CW + 1;
  localparam int unsigned BANKS       = 8;
  localparam int unsigned STORE_DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int unsigned IDX_W       = 15;
  localparam int unsigned VAL_W       = 16;
  localparam int unsigned CRD_W       = 18;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned SIZE_W      = 6;
  localparam int unsigned CUBE_W      = 16;
  localparam int unsigned ENTRY_W     = 3 * VAL_W;
  localparam int unsigned NSTG        = 7;
  localparam int unsigned S_TDATA_W   = 120;
  localparam int unsigned M_TDATA_W   = 48;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [CW-1:0]           cell_t;
  typedef logic [FRAC_W-1:0]       frac_t;

  // request presented to the table copies
  typedef struct packed {
    logic                              is_wr;
    logic                              wr_ok;
    logic [IDX_W-1:0]                  wr_addr;
    logic [ENTRY_W-1:0]                wr_data;
    logic [BANKS-1:0][IDX_W-1:0]       rd_addr;
    logic [2:0]                        clamp;
    logic [2:0][FRAC_W-1:0]            frac;
  } req_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(2)) r = SIZE_W'(2);
    else if (v > SIZE_W'(GRID_MAX)) r = SIZE_W'(GRID_MAX);
    else r = v;
    return r;
  endfunction

  // a + round((b-a)*t/65536), ties toward plus infinity
  function automatic val_t blend(input val_t a, input val_t b, input frac_t t);
    logic signed [VAL_W:0]   d;
    logic signed [33:0]      p;
    d = (VAL_W+1)'(b) - (VAL_W+1)'(a);
    p = 34'(d) * 34'(signed'({1'b0, t}));
    p = p + 34'sd32768;
    return a + VAL_W'(p >>> FRAC_W);
  endfunction

endpackage

[rtl/core/lts_ram.sv]
// ----------------------------------------------------------------------------
// lts_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module lts_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/lts_front.sv]
// ----------------------------------------------------------------------------
// lts_front
// coordinate split, neighbour selection and corner addressing (3 stages)
// ----------------------------------------------------------------------------
module lts_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_action_i,
  input  logic [lts_pkg::IDX_W-1:0]            in_index_i,
  input  logic [lts_pkg::ENTRY_W-1:0]          in_entry_i,
  input  logic [2:0][lts_pkg::CRD_W-1:0]       in_coord_i,
  input  logic [lts_pkg::SIZE_W-1:0]           size_i,
  input  logic [lts_pkg::CW-1:0]               last_i,
  input  logic [lts_pkg::CUBE_W-1:0]           cube_i,
  input  logic [2:0]                           en_i,
  output logic [2:0]                           valid_o,
  output lts_pkg::req_t                        req_o
);

  localparam int unsigned CW   = lts_pkg::CW;
  localparam int unsigned ZY_W = lts_pkg::ZY_W;

  // stage 1
  logic                            v1_q;
  logic                            act1_q;
  logic [lts_pkg::IDX_W-1:0]       idx1_q;
  logic                            inr1_q;
  logic [lts_pkg::ENTRY_W-1:0]     data1_q;
  logic [2:0][CW-1:0]              cell1_q, cell1_d;
  logic [2:0][lts_pkg::FRAC_W-1:0] frac1_q, frac1_d;

  // stage 2
  logic                            v2_q;
  logic                            act2_q;
  logic [lts_pkg::IDX_W-1:0]       idx2_q;
  logic                            inr2_q;
  logic [lts_pkg::ENTRY_W-1:0]     data2_q;
  logic [1:0][CW-1:0]              x2_q, x2_d;
  logic [3:0][ZY_W-1:0]            zy2_q, zy2_d;
  logic [2:0]                      clamp2_q, clamp2_d;
  logic [2:0][lts_pkg::FRAC_W-1:0] frac2_q;

  // stage 3
  logic                            v3_q;
  lts_pkg::req_t                   req3_q, req3_d;

  always_comb begin
    logic [16:0]    cc;
    logic [20:0]    s;
    for (int a = 0; a < 3; a++) begin
      if (in_coord_i[a][lts_pkg::CRD_W-1]) cc = 17'd0;
      else if (in_coord_i[a][16:0] > 17'd65536) cc = 17'd65536;
      else cc = in_coord_i[a][16:0];
      s = 21'(cc) * 21'(last_i);
      cell1_d[a] = s[20:16];
      frac1_d[a] = s[15:0];
    end
  end

  // far neighbour stops at the last grid point; row offsets z*n+y per corner
  always_comb begin
    logic [2:0][CW-1:0] nb;
    logic [1:0][CW-1:0] ys, zs;
    for (int a = 0; a < 3; a++) begin
      clamp2_d[a] = (cell1_q[a] == last_i);
      nb[a] = clamp2_d[a] ? cell1_q[a] : cell1_q[a] + CW'(1);
    end
    x2_d[0] = cell1_q[0];
    x2_d[1] = nb[0];
    ys[0]   = cell1_q[1];
    ys[1]   = nb[1];
    zs[0]   = cell1_q[2];
    zs[1]   = nb[2];
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 2; j++) begin
        zy2_d[2*k+j] = ZY_W'(zs[k]) * ZY_W'(size_i) + ZY_W'(ys[j]);
      end
    end
  end

  always_comb begin
    req3_d.is_wr   = (act2_q == lts_pkg::ACT_WRITE);
    req3_d.wr_ok   = (act2_q == lts_pkg::ACT_WRITE) && inr2_q;
    req3_d.wr_addr = idx2_q;
    req3_d.wr_data = data2_q;
    // corner c: bit 0 picks the red neighbour, bits 2:1 the row offset
    for (int c = 0; c < lts_pkg::BANKS; c++) begin
      req3_d.rd_addr[c] = lts_pkg::IDX_W'(zy2_q[c[2:1]]) * lts_pkg::IDX_W'(size_i) +
                          lts_pkg::IDX_W'(x2_q[c[0]]);
    end
    req3_d.clamp = clamp2_q;
    req3_d.frac  = frac2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en_i[0]) v1_q <= in_valid_i;
      if (en_i[1]) v2_q <= v1_q;
      if (en_i[2]) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      act1_q  <= in_action_i;
      idx1_q  <= in_index_i;
      inr1_q  <= ({1'b0, in_index_i} < cube_i);
      data1_q <= in_entry_i;
      cell1_q <= cell1_d;
      frac1_q <= frac1_d;
    end
    if (en_i[1]) begin
      act2_q   <= act1_q;
      idx2_q   <= idx1_q;
      inr2_q   <= inr1_q;
      data2_q  <= data1_q;
      x2_q     <= x2_d;
      zy2_q    <= zy2_d;
      clamp2_q <= clamp2_d;
      frac2_q  <= frac1_q;
    end
    if (en_i[2]) begin
      req3_q <= req3_d;
    end
  end

  assign valid_o = {v3_q, v2_q, v1_q};
  assign req_o   = req3_q;

endmodule

[rtl/core/lts_blend.sv]
// ----------------------------------------------------------------------------
// lts_blend
// trilinear blend of eight corners: red axis, green axis, blue axis (3 stages)
// ----------------------------------------------------------------------------
module lts_blend (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic [7:0][2:0][lts_pkg::VAL_W-1:0]  corner_i,
  input  logic [2:0]                           clamp_i,
  input  logic [2:0][lts_pkg::FRAC_W-1:0]      frac_i,
  input  logic [2:0]                           en_i,
  output logic [2:0]                           valid_o,
  output logic [2:0][lts_pkg::VAL_W-1:0]       rgb_o
);

  logic                               v5_q, v6_q, v7_q;
  logic [3:0][2:0][lts_pkg::VAL_W-1:0] c5_q, c5_d;
  logic [1:0][2:0][lts_pkg::VAL_W-1:0] c6_q, c6_d;
  logic [2:0][lts_pkg::VAL_W-1:0]      c7_q, c7_d;
  logic [2:1]                         clamp5_q;
  logic                               clamp6_q;
  logic [2:1][lts_pkg::FRAC_W-1:0]    frac5_q;
  logic [lts_pkg::FRAC_W-1:0]         frac6_q;

  // a clamped neighbour carries zero weight, so it is replaced by the near one
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        c5_d[r][c] = lts_pkg::blend(corner_i[2*r][c],
                       clamp_i[0] ? corner_i[2*r][c] : corner_i[2*r+1][c], frac_i[0]);
      end
    end
    for (int k = 0; k < 2; k++) begin
      for (int c = 0; c < 3; c++) begin
        c6_d[k][c] = lts_pkg::blend(c5_q[2*k][c],
                       clamp5_q[1] ? c5_q[2*k][c] : c5_q[2*k+1][c], frac5_q[1]);
      end
    end
    for (int c = 0; c < 3; c++) begin
      c7_d[c] = lts_pkg::blend(c6_q[0][c], clamp6_q ? c6_q[0][c] : c6_q[1][c], frac6_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en_i[0]) v5_q <= valid_i;
      if (en_i[1]) v6_q <= v5_q;
      if (en_i[2]) v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      c5_q     <= c5_d;
      clamp5_q <= clamp_i[2:1];
      frac5_q  <= frac_i[2:1];
    end
    if (en_i[1]) begin
      c6_q     <= c6_d;
      clamp6_q <= clamp5_q[2];
      frac6_q  <= frac5_q[2];
    end
    if (en_i[2]) begin
      c7_q <= c7_d;
    end
  end

  assign valid_o = {v7_q, v6_q, v5_q};
  assign rgb_o   = c7_q;

endmodule

[rtl/core/lut3d_trilinear_sampler_top.sv]
// ----------------------------------------------------------------------------
// lut3d_trilinear_sampler_top
// 3d colour lookup table with trilinear interpolation; unless stalled, one transaction a cycle
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_axis    in         tuser: action, tdata: index, entry rgb, coord rgb
// m_axis    out        tdata: interpolated rgb (one per sample)
// cfg       in         lut_size write
//
// seven register stages: coordinate scale, neighbour and row offset, corner
// addresses (3), table read from eight copies (1), blend per axis (3);
// one transaction per cycle while the output is not stalled.
// reset clears valid bits and sets lut_size to 2; table contents stay unknown.
// each stage holds only while the one after it is full and held, so a stalled
// output keeps filling the empty stages behind it.
// ----------------------------------------------------------------------------
`include "lut3d_trilinear_sampler_top_assert.svh"

module lut3d_trilinear_sampler_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: entry_index, entry_red, entry_green, entry_blue,
  //        coord_red, coord_green, coord_blue, zero pad
  input  logic [lts_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: action
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: out_red, out_green, out_blue
  output logic [lts_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [lts_pkg::SIZE_W-1:0]     cfg_wdata_i
);

  localparam int unsigned NSTG = lts_pkg::NSTG;

  logic [lts_pkg::SIZE_W-1:0] size_q, size_d;
  logic [lts_pkg::CW-1:0]     last_q;
  logic [lts_pkg::CUBE_W-1:0] cube_q;

  logic [NSTG-1:0]            en;
  logic [NSTG-1:0]            vld;
  lts_pkg::req_t              req3;
  logic [2:0]                 front_v, blend_v;
  logic                       v4_q;
  logic [2:0]                 clamp4_q;
  logic [2:0][lts_pkg::FRAC_W-1:0] frac4_q;
  logic [lts_pkg::BANKS-1:0]  bank_we;
  logic [lts_pkg::BANKS-1:0][lts_pkg::ENTRY_W-1:0] bank_rd;
  logic [7:0][2:0][lts_pkg::VAL_W-1:0] corner;
  logic [2:0][lts_pkg::VAL_W-1:0] rgb;
  logic [2:0][lts_pkg::CRD_W-1:0] coord;

  assign size_d = lts_pkg::eff_size(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= lts_pkg::SIZE_W'(2);
      last_q  <= lts_pkg::CW'(1);
      cube_q  <= lts_pkg::CUBE_W'(8);
    end else if (cfg_we_i) begin
      size_q  <= size_d;
      last_q  <= lts_pkg::CW'(size_d - lts_pkg::SIZE_W'(1));
      cube_q  <= lts_pkg::CUBE_W'(size_d) * lts_pkg::CUBE_W'(size_d) *
                 lts_pkg::CUBE_W'(size_d);
    end
  end

  // stage k loads when it is empty or the stage after it moves on
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld = {blend_v, v4_q, front_v};
  assign s_axis_tready = en[0];

  assign coord[0] = s_axis_tdata[63 +: lts_pkg::CRD_W];
  assign coord[1] = s_axis_tdata[81 +: lts_pkg::CRD_W];
  assign coord[2] = s_axis_tdata[99 +: lts_pkg::CRD_W];

  lts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_index_i  (s_axis_tdata[lts_pkg::IDX_W-1:0]),
    .in_entry_i  (s_axis_tdata[lts_pkg::IDX_W +: lts_pkg::ENTRY_W]),
    .in_coord_i  (coord),
    .size_i      (size_q),
    .last_i      (last_q),
    .cube_i      (cube_q),
    .en_i        (en[2:0]),
    .valid_o     (front_v),
    .req_o       (req3)
  );

  // eight copies of the linear table, one read port per corner
  for (genvar b = 0; b < lts_pkg::BANKS; b++) begin : g_bank
    assign bank_we[b] = en[3] && front_v[2] && req3.wr_ok;
    lts_ram #(
      .WIDTH (lts_pkg::ENTRY_W),
      .DEPTH (lts_pkg::STORE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .en_i    (en[3]),
      .we_i    (bank_we[b]),
      .addr_i  (req3.is_wr ? req3.wr_addr : req3.rd_addr[b]),
      .wdata_i (req3.wr_data),
      .rdata_o (bank_rd[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en[3]) begin
      v4_q <= front_v[2] && !req3.is_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      clamp4_q <= req3.clamp;
      frac4_q  <= req3.frac;
    end
  end

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      corner[c] = bank_rd[c];
    end
  end

  lts_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v4_q),
    .corner_i (corner),
    .clamp_i  (clamp4_q),
    .frac_i   (frac4_q),
    .en_i     (en[6:4]),
    .valid_o  (blend_v),
    .rgb_o    (rgb)
  );

  assign m_axis_tvalid = blend_v[2];
  assign m_axis_tdata  = rgb;

  `LTS_ASSERT_IMP(a_stall_only_on_full_output, !s_axis_tready, m_axis_tvalid,
                  "input stalled while output empty")
  `LTS_ASSERT_NXT(a_output_held, m_axis_tvalid && !m_axis_tready,
                  m_axis_tvalid && $stable(m_axis_tdata),
                  "output changed while stalled")
  `LTS_ASSERT_NXT(a_write_gives_no_result, |bank_we, !v4_q,
                  "write transaction entered read stage as valid")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3d lut trilinear sampler. The table is first
// filled up to the largest grid that is sampled freely, so a sample never
// reads an unwritten entry. Then directed and random write/sample streams run
// at several grid sizes; at the clamped top size samples stay in the first cell.
// Each sample is predicted on acceptance and checked against the output stream.
// ----------------------------------------------------------------------------
module tb;
  import lts_pkg::*;

  localparam int unsigned DEPTH     = GRID_MAX * GRID_MAX * GRID_MAX;
  localparam int unsigned WDOG_MAX  = 5000;
  localparam int unsigned DRAIN_CYC = 20;

  typedef struct {
    logic                    act;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] er, eg, eb;
    logic signed [CRD_W-1:0] cr, cg, cb;
  } lut_item_t;

  typedef struct {
    logic signed [VAL_W-1:0] r, g, b;
  } rgb_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   cfg_we_i;
  logic [SIZE_W-1:0]      cfg_wdata_i;

  lut3d_trilinear_sampler_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  lut_item_t pending_q[$];
  rgb_t      colour_q[$];

  logic signed [VAL_W-1:0] tab_r[DEPTH];
  logic signed [VAL_W-1:0] tab_g[DEPTH];
  logic signed [VAL_W-1:0] tab_b[DEPTH];
  logic [SIZE_W-1:0]       grid_reg;

  int  idle_mode;
  bit  took;
  int  mismatches, unexpected, samples_seen, writes_sent;
  int  wdog;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned grid_n();
    if (grid_reg < 2) return 2;
    if (grid_reg > GRID_MAX) return GRID_MAX;
    return grid_reg;
  endfunction

  function automatic logic signed [VAL_W-1:0] lerp(logic signed [VAL_W-1:0] a,
                                                   logic signed [VAL_W-1:0] b,
                                                   int unsigned t);
    longint v;
    v = (longint'(b) - longint'(a)) * longint'(t) + 64'sd32768;
    return VAL_W'(longint'(a) + (v >>> 16));
  endfunction

  function automatic rgb_t interp_colour(lut_item_t it);
    int unsigned n, last, s, cix[3], nxt[3], fr[3];
    int          c;
    logic signed [CRD_W-1:0] crd[3];
    logic signed [VAL_W-1:0] v[8], c00, c10, c01, c11, c0, c1, res[3];
    int unsigned k, ax;
    crd[0] = it.cr; crd[1] = it.cg; crd[2] = it.cb;
    n = grid_n();
    last = n - 1;
    for (ax = 0; ax < 3; ax++) begin
      c = crd[ax];
      if (c < 0) c = 0;
      if (c > 65536) c = 65536;
      s = c * last;
      cix[ax] = s >> 16;
      fr[ax] = s & 32'hFFFF;
      nxt[ax] = (cix[ax] + 1 > last) ? last : cix[ax] + 1;
    end
    for (k = 0; k < 3; k++) begin
      for (int j = 0; j < 8; j++) begin
        int unsigned x, y, z, id;
        x = j[0] ? nxt[0] : cix[0];
        y = j[1] ? nxt[1] : cix[1];
        z = j[2] ? nxt[2] : cix[2];
        id = (z * n + y) * n + x;
        v[j] = (k == 0) ? tab_r[id] : (k == 1) ? tab_g[id] : tab_b[id];
      end
      c00 = lerp(v[0], v[1], fr[0]);
      c10 = lerp(v[2], v[3], fr[0]);
      c01 = lerp(v[4], v[5], fr[0]);
      c11 = lerp(v[6], v[7], fr[0]);
      c0  = lerp(c00, c10, fr[1]);
      c1  = lerp(c01, c11, fr[1]);
      res[k] = lerp(c0, c1, fr[2]);
    end
    interp_colour.r = res[0];
    interp_colour.g = res[1];
    interp_colour.b = res[2];
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_item(lut_item_t it);
    return {3'b000, it.cb, it.cg, it.cr, it.eb, it.eg, it.er, it.idx};
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 19;
      1: return $urandom_range(0, 99) < 45;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 45;
      1: return $urandom_range(0, 99) < 19;
      default: return 1'b0;
    endcase
  endfunction

  // driver: next transaction goes out on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || took) begin
        took = 1'b0;
        if (pending_q.size() > 0 && !sender_idles()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pack_item(pending_q[0]);
          s_axis_tuser  <= pending_q[0].act;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !receiver_idles();
    end
  end

  // monitor: input acceptance, prediction, output check
  always @(posedge clk_i) begin
    lut_item_t it;
    rgb_t      want, got;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we_i) grid_reg = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        it = pending_q.pop_front();
        took = 1'b1;
        moved = 1'b1;
        if (it.act == ACT_SAMPLE) begin
          colour_q.push_back(interp_colour(it));
        end else if (it.idx < grid_n() ** 3) begin
          tab_r[it.idx] = it.er;
          tab_g[it.idx] = it.eg;
          tab_b[it.idx] = it.eb;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got.r = m_axis_tdata[15:0];
        got.g = m_axis_tdata[31:16];
        got.b = m_axis_tdata[47:32];
        if (colour_q.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10)
            $display("unexpected result r=%0d g=%0d b=%0d", got.r, got.g, got.b);
        end else begin
          want = colour_q.pop_front();
          samples_seen++;
          if (want.r !== got.r || want.g !== got.g || want.b !== got.b) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
              $display("mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       want.r, want.g, want.b, got.r, got.g, got.b);
          end
        end
      end
      wdog = moved ? 0 : wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic signed [CRD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CRD_W'(65536);
      2: return CRD_W'($urandom);
      3: return CRD_W'($urandom_range(0, 65536));
      default: return CRD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // stays in the first cell at the largest grid
  function automatic logic signed [CRD_W-1:0] low_coord();
    return CRD_W'($urandom_range(0, 2113));
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic push_write(int unsigned idx, logic signed [VAL_W-1:0] r,
                            logic signed [VAL_W-1:0] g, logic signed [VAL_W-1:0] b);
    lut_item_t it;
    it.act = ACT_WRITE; it.idx = IDX_W'(idx);
    it.er = r; it.eg = g; it.eb = b;
    it.cr = CRD_W'($urandom); it.cg = CRD_W'($urandom); it.cb = CRD_W'($urandom);
    pending_q.push_back(it);
    writes_sent++;
  endtask

  task automatic push_sample(logic signed [CRD_W-1:0] r, logic signed [CRD_W-1:0] g,
                             logic signed [CRD_W-1:0] b);
    lut_item_t it;
    it.act = ACT_SAMPLE; it.idx = IDX_W'($urandom);
    it.er = VAL_W'($urandom); it.eg = VAL_W'($urandom); it.eb = VAL_W'($urandom);
    it.cr = r; it.cg = g; it.cb = b;
    pending_q.push_back(it);
  endtask

  task automatic wait_idle();
    wait (pending_q.size() == 0 && !s_axis_tvalid && colour_q.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic set_grid(logic [SIZE_W-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes[9];
    logic signed [CRD_W-1:0] pts[6];
    int unsigned n3;
    sizes = '{6'd8, 6'd2, 6'd8, 6'd7, 6'd0, 6'd63, 6'd5, 6'd1, 6'd3};
    pts   = '{18'sd0, 18'sd65536, -18'sd131072, 18'sd131071, 18'sd32768, 18'sd1};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0; cfg_we_i = 1'b0; cfg_wdata_i = '0;
    grid_reg = 6'd2; took = 1'b0; idle_mode = 0; wdog = 0;
    mismatches = 0; unexpected = 0; samples_seen = 0; writes_sent = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    for (int ph = 0; ph < 9; ph++) begin
      idle_mode = ph / 3;
      set_grid(sizes[ph]);
      n3 = grid_n() ** 3;
      if (ph == 0) begin
        // every entry of the freely sampled grids written once
        for (int i = 0; i < n3; i++) push_write(i, rand_val(), rand_val(), rand_val());
        continue;
      end
      if (ph == 1) begin
        push_write(0, 16'sh7FFF, 16'sh8000, 16'sh0000);
        push_write(7, 16'sh8000, 16'sh7FFF, 16'shFFFF);
        push_write(3, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        push_write(8, 16'sh1234, 16'sh1234, 16'sh1234);      // beyond size^3, dropped
        push_write(32767, 16'sh0001, 16'sh0002, 16'sh0003); // dropped too
        for (int k = 0; k < 6; k++) push_sample(pts[k], pts[(k + 1) % 6], pts[(k + 3) % 6]);
        push_sample(pts[4], pts[4], pts[4]);
        push_sample(pts[3], pts[3], pts[3]);
        push_sample(pts[2], pts[2], pts[2]);
      end
      if (n3 >= DEPTH) begin
        // corners of the first cell at the largest grid
        for (int j = 0; j < 8; j++)
          push_write((j % 2) + (j / 2 % 2) * GRID_MAX + (j / 4) * GRID_MAX * GRID_MAX,
                     rand_val(), rand_val(), rand_val());
      end
      for (int i = 0; i < 185; i++) begin
        if ($urandom_range(0, 9) < 6) begin
          if (n3 < DEPTH)
            push_sample(rand_coord(), rand_coord(), rand_coord());
          else
            push_sample(low_coord(), low_coord(), low_coord());
        end else if ($urandom_range(0, 9) < 7)
          push_write($urandom_range(0, n3 - 1), rand_val(), rand_val(), rand_val());
        else
          push_write($urandom_range(0, DEPTH - 1), rand_val(), rand_val(), rand_val());
      end
    end
    wait_idle();
    $display("covered %0d table writes and %0d checked samples over 9 grid sizes",
             writes_sent, samples_seen);
    $display("edge cells, clamped coordinates and dropped writes included");
    if (mismatches == 0 && unexpected == 0 && colour_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
